>>> rtl/core/audio_agc_attack_release_top_assert.svh
// Assertion macros for the checker file of the gain control block.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef AUDIO_AGC_ATTACK_RELEASE_TOP_ASSERT_SVH
`define AUDIO_AGC_ATTACK_RELEASE_TOP_ASSERT_SVH

// Overlapping implication: cons must hold in the cycle where ante matches.
`define AGC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("agc assertion failed");

// Next-cycle implication: cons must hold in the cycle after ante matches.
`define AGC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("agc assertion failed");

`endif

>>> rtl/core/agc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package agc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 15;
    localparam int GAIN_W    = 32;
    localparam int CFG_IDX_W = 3;

    // Gain is Q10 in the upper half; the product needs 15 - 10 more bits of
    // shift plus one for the fractional multiply.
    localparam int GAIN_FRAC_BITS = 10;
    localparam int PROD_SHIFT     = 15 - GAIN_FRAC_BITS + 1;

    localparam logic signed [GAIN_W-1:0] GAIN_RESET = 32'sh0400_0000;
    localparam logic signed [GAIN_W-1:0] MAX32      = 32'sh7FFF_FFFF;
    localparam logic signed [GAIN_W-1:0] MIN32      = 32'sh8000_0000;
    localparam logic signed [SAMPLE_W-1:0] MIN16    = 16'sh8000;
    localparam logic [COEF_W-1:0] MAX15             = 15'h7FFF;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_COEF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_COEF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAIN     = 3'd4;

    localparam logic [COEF_W-1:0] ATTACK_COEF_RST  = 15'd32440;
    localparam logic [COEF_W-1:0] RELEASE_COEF_RST = 15'd64;
    localparam logic [COEF_W-1:0] TARGET_LEVEL_RST = 15'd16384;
    localparam logic [COEF_W-1:0] MAX_GAIN_RST     = 15'd32767;
    localparam logic [COEF_W-1:0] MIN_GAIN_RST     = 15'd0;

    typedef struct packed {
        logic [COEF_W-1:0] attack_coef;
        logic [COEF_W-1:0] release_coef;
        logic [COEF_W-1:0] target_level;
        logic [COEF_W-1:0] max_gain;
        logic [COEF_W-1:0] min_gain;
    } t_cfg;

    // Saturate a 33-bit signed value to 32 bits.
    function automatic logic signed [GAIN_W-1:0] sat33(input logic signed [GAIN_W:0] v);
        logic signed [GAIN_W-1:0] r;
        if (v[GAIN_W] != v[GAIN_W-1]) begin
            r = v[GAIN_W] ? MIN32 : MAX32;
        end else begin
            r = v[GAIN_W-1:0];
        end
        return r;
    endfunction

    // Add half an LSB of the upper half with saturation, keep the upper half.
    function automatic logic signed [SAMPLE_W-1:0] round_h(input logic signed [GAIN_W-1:0] v);
        logic signed [GAIN_W:0] s;
        logic signed [GAIN_W-1:0] t;
        s = {v[GAIN_W-1], v} + 33'sd32768;
        t = sat33(s);
        return t[GAIN_W-1:SAMPLE_W];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/agc_sample_path.sv
`timescale 1ns / 1ps
`default_nettype none

module agc_sample_path (
    input  wire logic signed [agc_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic signed [agc_pkg::SAMPLE_W-1:0] i_gain_hi,
    input  wire logic        [agc_pkg::COEF_W-1:0]   i_target_level,
    output logic signed      [agc_pkg::SAMPLE_W-1:0] o_sample,
    output logic                                     o_overshoot
);
    import agc_pkg::*;

    localparam int WIDE_W = GAIN_W + PROD_SHIFT;

    logic signed [GAIN_W-1:0] w_prod;
    logic signed [WIDE_W-1:0] w_wide;
    logic signed [GAIN_W-1:0] w_sat;
    logic signed [SAMPLE_W-1:0] w_y;
    logic [COEF_W-1:0] w_mag;

    assign w_prod = i_sample * i_gain_hi;
    assign w_wide = {w_prod, {PROD_SHIFT{1'b0}}};

    // Saturate when the bits above bit 31 are not all sign copies.
    always_comb begin
        if (&w_wide[WIDE_W-1:GAIN_W-1] || ~|w_wide[WIDE_W-1:GAIN_W-1]) begin
            w_sat = w_wide[GAIN_W-1:0];
        end else begin
            w_sat = w_wide[WIDE_W-1] ? MIN32 : MAX32;
        end
    end

    assign w_y = round_h(w_sat);

    // Saturating magnitude: the most negative code counts as full scale.
    always_comb begin
        if (w_y == MIN16) begin
            w_mag = MAX15;
        end else if (w_y[SAMPLE_W-1]) begin
            w_mag = COEF_W'(-w_y);
        end else begin
            w_mag = w_y[COEF_W-1:0];
        end
    end

    assign o_sample    = w_y;
    assign o_overshoot = i_target_level < w_mag;

endmodule

`default_nettype wire

>>> rtl/core/agc_gain_update.sv
`timescale 1ns / 1ps
`default_nettype none

module agc_gain_update (
    input  wire logic signed [agc_pkg::GAIN_W-1:0] i_gain,
    input  wire agc_pkg::t_cfg                     i_cfg,
    input  wire logic                              i_overshoot,
    output logic signed      [agc_pkg::GAIN_W-1:0] o_gain
);
    import agc_pkg::*;

    localparam int STEP_W = COEF_W - 2;
    localparam int REL_W  = STEP_W + COEF_W;

    logic signed [SAMPLE_W-1:0] w_rg;
    logic signed [GAIN_W-1:0]   w_att_prod;
    logic signed [GAIN_W-1:0]   w_att;
    logic signed [SAMPLE_W:0]   w_step_full;
    logic [COEF_W-1:0]          w_step_sat;
    logic [STEP_W-1:0]          w_step;
    logic [REL_W-1:0]           w_rel_prod;
    logic signed [GAIN_W:0]     w_rel_sum;
    logic signed [GAIN_W-1:0]   w_rel;
    logic signed [GAIN_W-1:0]   w_hi;
    logic signed [GAIN_W-1:0]   w_lo;
    logic signed [GAIN_W-1:0]   w_att_clamped;
    logic signed [GAIN_W-1:0]   w_rel_clamped;

    assign w_rg = round_h(i_gain);

    // Attack: scale the rounded gain by a Q15 coefficient; cannot overflow.
    assign w_att_prod = w_rg * $signed({1'b0, i_cfg.attack_coef});
    assign w_att      = {w_att_prod[GAIN_W-2:0], 1'b0};

    // Release: quarter of the distance to full scale, weighted in Q15.
    assign w_step_full = 17'sd32767 - {w_rg[SAMPLE_W-1], w_rg};
    assign w_step_sat  = (w_step_full[SAMPLE_W] | w_step_full[SAMPLE_W-1]) ? MAX15
                                                                         : w_step_full[COEF_W-1:0];
    assign w_step      = w_step_sat[COEF_W-1:2];
    assign w_rel_prod  = w_step * i_cfg.release_coef;
    assign w_rel_sum   = {i_gain[GAIN_W-1], i_gain}
                       + {{(GAIN_W-REL_W){1'b0}}, w_rel_prod, 1'b0};
    assign w_rel       = sat33(w_rel_sum);

    assign w_hi = {1'b0, i_cfg.max_gain, {SAMPLE_W{1'b0}}};
    assign w_lo = {1'b0, i_cfg.min_gain, {SAMPLE_W{1'b0}}};

    // Clamp both candidates in parallel; the lower bound wins last.
    always_comb begin
        w_att_clamped = (w_att > w_hi) ? w_hi : w_att;
        if (w_att_clamped < w_lo) begin
            w_att_clamped = w_lo;
        end
        w_rel_clamped = (w_rel > w_hi) ? w_hi : w_rel;
        if (w_rel_clamped < w_lo) begin
            w_rel_clamped = w_lo;
        end
    end

    assign o_gain = i_overshoot ? w_att_clamped : w_rel_clamped;

endmodule

`default_nettype wire

>>> rtl/core/audio_agc_attack_release_top.sv
// Channel | Direction | Handshake                 | Payload
// input   | in        | i_in_valid / o_in_ready   | i_sample_in, i_block_end
// output  | out       | o_out_valid / i_out_ready | o_sample_out, o_block_end_out
// config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One sample per cycle sustained while the output side accepts; a transferred sample
// passes the input register, then the result register. The gain feedback loop (multiply,
// round, compare, update, clamp) closes combinationally between input and result register.
// Reset is synchronous: control and configuration registers return to defaults and gain to unity (Q10).
// Stalls on the output back up into the input register, then into o_in_ready.
`timescale 1ns / 1ps
`default_nettype none

module audio_agc_attack_release_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,

    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic signed [agc_pkg::SAMPLE_W-1:0]  i_sample_in,
    input  wire logic                                 i_block_end,

    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic signed      [agc_pkg::SAMPLE_W-1:0]  o_sample_out,
    output logic                                      o_block_end_out,

    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic        [agc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic        [agc_pkg::COEF_W-1:0]    i_cfg_data
);
    import agc_pkg::*;

    // Configuration registers
    t_cfg r_cfg;
    t_cfg n_cfg;

    // Gain state (Q10 in the upper half)
    logic signed [GAIN_W-1:0] r_gain;
    logic signed [GAIN_W-1:0] n_gain;

    // Input register
    logic                       r_in_valid;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_block_end;

    // Result register
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_sample_out;
    logic                       r_block_end_out;

    logic signed [SAMPLE_W-1:0] n_sample_out;
    logic                       w_overshoot;
    logic                       w_advance;
    logic                       w_in_xfer;

    // Move the held sample forward when the result register is free or draining.
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || !r_out_valid || i_out_ready;
    assign w_in_xfer  = i_in_valid && o_in_ready;

    assign o_cfg_ready = 1'b1;

    // Decode a configuration transfer; unknown indexes drop the write.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ATTACK_COEF:  n_cfg.attack_coef  = i_cfg_data;
                CFG_RELEASE_COEF: n_cfg.release_coef = i_cfg_data;
                CFG_TARGET_LEVEL: n_cfg.target_level = i_cfg_data;
                CFG_MAX_GAIN:     n_cfg.max_gain     = i_cfg_data;
                CFG_MIN_GAIN:     n_cfg.min_gain     = i_cfg_data;
                default:          n_cfg              = r_cfg;
            endcase
        end
    end

    // Scale the held sample by the current gain and flag overshoot.
    agc_sample_path u_sample_path (
        .i_sample       (r_sample),
        .i_gain_hi      (r_gain[GAIN_W-1:SAMPLE_W]),
        .i_target_level (r_cfg.target_level),
        .o_sample       (n_sample_out),
        .o_overshoot    (w_overshoot)
    );

    // Both candidate gains are formed in parallel; overshoot picks one.
    agc_gain_update u_gain_update (
        .i_gain      (r_gain),
        .i_cfg       (r_cfg),
        .i_overshoot (w_overshoot),
        .o_gain      (n_gain)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_coef  <= ATTACK_COEF_RST;
            r_cfg.release_coef <= RELEASE_COEF_RST;
            r_cfg.target_level <= TARGET_LEVEL_RST;
            r_cfg.max_gain     <= MAX_GAIN_RST;
            r_cfg.min_gain     <= MIN_GAIN_RST;
            r_gain             <= GAIN_RESET;
            r_in_valid         <= 1'b0;
            r_out_valid        <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
            // Update gain only when a sample actually moves to the result register.
            if (w_advance) begin
                r_gain <= n_gain;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: hold while stalled, no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_sample    <= i_sample_in;
            r_block_end <= i_block_end;
        end
        if (w_advance) begin
            r_sample_out    <= n_sample_out;
            r_block_end_out <= r_block_end;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sample_out    = r_sample_out;
    assign o_block_end_out = r_block_end_out;

endmodule

`default_nettype wire

>>> rtl/core/agc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "audio_agc_attack_release_top_assert.svh"

module agc_checker (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 i_in_valid,
    input wire logic                                 o_in_ready,
    input wire logic signed [agc_pkg::SAMPLE_W-1:0]  i_sample_in,
    input wire logic                                 i_block_end,
    input wire logic                                 o_out_valid,
    input wire logic                                 i_out_ready,
    input wire logic signed [agc_pkg::SAMPLE_W-1:0]  o_sample_out,
    input wire logic                                 o_block_end_out
);
    import agc_pkg::*;

    // A stalled result stays offered.
    `AGC_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)

    // A stalled result keeps its payload.
    `AGC_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_sample_out))

    // A transfer whose sample then finds the result side open reaches the output with its flag.
    `AGC_ASSERT_NEXT(a_flag_latency, (i_in_valid && o_in_ready) ##1 (!o_out_valid || i_out_ready), o_out_valid && (o_block_end_out == $past(i_block_end, 2)))

    // Silence in gives silence out, whatever the gain.
    `AGC_ASSERT_NEXT(a_zero_in_zero_out, (i_in_valid && o_in_ready && (i_sample_in == '0)) ##1 (!o_out_valid || i_out_ready), o_sample_out == '0)

endmodule

bind audio_agc_attack_release_top agc_checker u_agc_checker (.*);

`default_nettype wire
